// File: design/dtok_pkg.sv
// ----------------------------------------------------------------------------
// dtok_pkg
// Shared types and constants of the delimiter tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dtok_pkg;

    // Widths of the result fields and of the configuration port, set size and queue depth
    localparam int FIELD_W      = 16;
    localparam int EXT_W        = 32;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 6;
    localparam int CFG_REGS     = 8;
    localparam int SET_BITS     = 256;
    localparam int DEF_OFFSET_BITS = 16;
    localparam int QUEUE_DEPTH  = 4;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] SEP_SET_0_RST  = 64'd4294977024;
    localparam logic [CFG_DATA_W-1:0] SKIP_SET_0_RST = 64'd4294967808;

    // Register indexes
    typedef enum logic [2:0] {
        REG_SEP_0  = 3'd0,
        REG_SEP_1  = 3'd1,
        REG_SEP_2  = 3'd2,
        REG_SEP_3  = 3'd3,
        REG_SKIP_0 = 3'd4,
        REG_SKIP_1 = 3'd5,
        REG_SKIP_2 = 3'd6,
        REG_SKIP_3 = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        CAUSE_SEP = 2'd0,
        CAUSE_NUL = 2'd1,
        CAUSE_END = 2'd2
    } t_cause;

    // Byte class decided by the front end
    typedef enum logic [2:0] {
        KIND_HALTED,
        KIND_NUL,
        KIND_SKIP,
        KIND_SEP,
        KIND_TEXT
    } t_kind;

    typedef struct packed {
        logic [FIELD_W-1:0] offset;
        logic [FIELD_W-1:0] length;
        t_cause             cause;
        logic               final_r;
    } t_result;

    // Results caused by one item: first, and optionally a second
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_pair;

    typedef struct packed {
        logic  push;
        t_pair data;
    } t_push;

    typedef struct packed {
        logic  valid;
        t_pair data;
    } t_head;

endpackage

`default_nettype wire

// File: design/delimiter_tokenizer.sv
// Path: an accepted item's results go through the result-pair queue to the output register.
// Throughput: one item per cycle while the queue has space; results leave at one per
//   cycle through the output register while the receiver is ready; a second result waits.
// Input ready drops only when the four-entry result-pair queue is full.
// Reset: synchronous, active low; clears token state, queue and output valid,
//   and returns both byte sets to their default contents.
// ----------------------------------------------------------------------------
// delimiter_tokenizer
// Splits a byte stream into tokens by configurable separator and left-skip
// sets, reporting each token's offset, length and end cause.
// ----------------------------------------------------------------------------
`default_nettype none

module delimiter_tokenizer
    import dtok_pkg::*;
#(
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // byte input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [7:0]            i_text_byte,
    input  wire logic                  i_buffer_end,
    // token output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [FIELD_W-1:0]         o_token_offset,
    output logic [FIELD_W-1:0]         o_token_length,
    output logic [1:0]                 o_end_cause,
    output logic                       o_final_result,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [SET_BITS-1:0] sep_set;
    logic [SET_BITS-1:0] skip_set;
    logic                q_space;
    t_push               push;
    t_head               head;
    logic                pop;
    t_result             res;

    // Register writes complete in the access phase; no wait states.
    assign pready = 1'b1;

    // Byte sets: bit b of each 256-bit vector stands for byte value b
    dtok_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .o_sep_set  (sep_set),
        .o_skip_set (skip_set)
    );

    // Front end: classifies each byte and forms zero, one or two results
    // for it in the cycle it is accepted.
    dtok_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_text_byte  (i_text_byte),
        .i_buffer_end (i_buffer_end),
        .i_sep_set    (sep_set),
        .i_skip_set   (skip_set),
        .i_space      (q_space),
        .o_push       (push)
    );

    // Queue of result pairs decouples the byte side from the token side
    dtok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (q_space),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Back end: splits pairs into single results behind an output register
    dtok_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (res)
    );

    assign o_token_offset = res.offset;
    assign o_token_length = res.length;
    assign o_end_cause    = res.cause;
    assign o_final_result = res.final_r;

endmodule

`default_nettype wire

// File: design/dtok_regs.sv
// ----------------------------------------------------------------------------
// dtok_regs
// APB register file holding the separator and left-skip byte sets.
// ----------------------------------------------------------------------------
`default_nettype none

module dtok_regs
    import dtok_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic      [SET_BITS-1:0]   o_sep_set,
    output logic      [SET_BITS-1:0]   o_skip_set
);

    logic [CFG_DATA_W-1:0] r_regs [CFG_REGS];
    t_reg_idx              idx;
    logic                  wr;

    assign idx = t_reg_idx'(paddr[CFG_ADDR_W-1:3]);
    assign wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[REG_SEP_0]  <= SEP_SET_0_RST;
            r_regs[REG_SEP_1]  <= '0;
            r_regs[REG_SEP_2]  <= '0;
            r_regs[REG_SEP_3]  <= '0;
            r_regs[REG_SKIP_0] <= SKIP_SET_0_RST;
            r_regs[REG_SKIP_1] <= '0;
            r_regs[REG_SKIP_2] <= '0;
            r_regs[REG_SKIP_3] <= '0;
        end else if (wr) begin
            r_regs[idx] <= pwdata;
        end
    end

    assign prdata     = r_regs[idx];
    assign o_sep_set  = {r_regs[REG_SEP_3], r_regs[REG_SEP_2],
                         r_regs[REG_SEP_1], r_regs[REG_SEP_0]};
    assign o_skip_set = {r_regs[REG_SKIP_3], r_regs[REG_SKIP_2],
                         r_regs[REG_SKIP_1], r_regs[REG_SKIP_0]};

endmodule

`default_nettype wire

// File: design/dtok_front.sv
// ----------------------------------------------------------------------------
// dtok_front
// Accepts bytes, classifies them against the sets and tracks token state.
// ----------------------------------------------------------------------------
`default_nettype none

module dtok_front
    import dtok_pkg::*;
#(
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [7:0]          i_text_byte,
    input  wire logic                i_buffer_end,
    input  wire logic [SET_BITS-1:0] i_sep_set,
    input  wire logic [SET_BITS-1:0] i_skip_set,
    input  wire logic                i_space,
    output t_push                    o_push
);

    logic [OFFSET_BITS-1:0] r_pos,      n_pos;
    logic [OFFSET_BITS-1:0] r_tok_begin, n_tok_begin;
    logic                   r_at_start, n_at_start;
    logic                   r_halted,   n_halted;

    logic [OFFSET_BITS-1:0] next_pos;
    logic                   acc;
    t_kind                  kind;
    t_pair                  pair;
    logic                   any;

    // Saturate to the result field width
    function automatic logic [FIELD_W-1:0] clamp(input logic [OFFSET_BITS-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return (ext[EXT_W-1:FIELD_W] != '0) ? '1 : ext[FIELD_W-1:0];
    endfunction

    function automatic t_result mk(input logic [OFFSET_BITS-1:0] off,
                                   input logic [OFFSET_BITS-1:0] len,
                                   input t_cause cause, input logic fin);
        t_result r;
        r.offset  = clamp(off);
        r.length  = clamp(len);
        r.cause   = cause;
        r.final_r = fin;
        return r;
    endfunction

    assign acc      = i_valid && i_space;
    assign o_ready  = i_space;
    assign next_pos = (r_pos == '1) ? r_pos : r_pos + 1'b1;

    always_comb begin
        priority if (r_halted) begin
            kind = KIND_HALTED;
        end else if (i_text_byte == 8'd0) begin
            kind = KIND_NUL;
        end else if (r_at_start && i_skip_set[i_text_byte]) begin
            kind = KIND_SKIP;
        end else if (i_sep_set[i_text_byte]) begin
            kind = KIND_SEP;
        end else begin
            kind = KIND_TEXT;
        end
    end

    always_comb begin
        n_pos       = r_pos;
        n_tok_begin = r_tok_begin;
        n_at_start  = r_at_start;
        n_halted    = r_halted;
        pair        = '0;
        any         = 1'b0;

        unique case (kind)
            KIND_HALTED: ;
            KIND_NUL: begin
                pair.r0  = mk(r_tok_begin, r_pos - r_tok_begin, CAUSE_NUL, 1'b1);
                any      = 1'b1;
                n_halted = 1'b1;
            end
            KIND_SKIP: begin
                n_tok_begin = next_pos;
                n_pos       = next_pos;
            end
            KIND_SEP: begin
                pair.r0     = mk(r_tok_begin, r_pos - r_tok_begin, CAUSE_SEP, 1'b0);
                any         = 1'b1;
                n_tok_begin = next_pos;
                n_at_start  = 1'b1;
                n_pos       = next_pos;
            end
            KIND_TEXT: begin
                n_at_start = 1'b0;
                n_pos      = next_pos;
            end
            default: ;
        endcase

        // End of buffer flushes the pending token
        if (i_buffer_end && kind != KIND_HALTED && kind != KIND_NUL) begin
            if (kind == KIND_SEP) begin
                pair.two = 1'b1;
                pair.r1  = mk(n_tok_begin, next_pos - n_tok_begin, CAUSE_END, 1'b1);
            end else begin
                pair.r0  = mk(n_tok_begin, next_pos - n_tok_begin, CAUSE_END, 1'b1);
            end
            any = 1'b1;
        end

        if (i_buffer_end) begin
            n_pos       = '0;
            n_tok_begin = '0;
            n_at_start  = 1'b1;
            n_halted    = 1'b0;
        end
    end

    assign o_push.push = acc && any;
    assign o_push.data = pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_tok_begin <= '0;
            r_at_start  <= 1'b1;
            r_halted    <= 1'b0;
        end else if (acc) begin
            r_pos       <= n_pos;
            r_tok_begin <= n_tok_begin;
            r_at_start  <= n_at_start;
            r_halted    <= n_halted;
        end
    end

endmodule

`default_nettype wire

// File: design/dtok_queue.sv
// ----------------------------------------------------------------------------
// dtok_queue
// Short FIFO of result pairs between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dtok_queue
    import dtok_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_space,
    output t_head      o_head,
    input  wire logic  i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_pair              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_pop;

    assign o_space      = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.data  = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push.push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/dtok_back.sv
// ----------------------------------------------------------------------------
// dtok_back
// Unpacks result pairs into a registered one-result-per-cycle output while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dtok_back
    import dtok_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_head i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_result
);

    logic    r_valid;
    t_result r_res;
    logic    r_pend_valid;
    t_result r_pend;
    logic    load;

    assign load  = !r_valid || i_ready;
    assign o_pop = load && !r_pend_valid && i_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (load) begin
            if (r_pend_valid) begin
                r_valid      <= 1'b1;
                r_pend_valid <= 1'b0;
            end else begin
                r_valid      <= i_head.valid;
                r_pend_valid <= i_head.valid && i_head.data.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend_valid) begin
                r_res <= r_pend;
            end else if (i_head.valid) begin
                r_res  <= i_head.data.r0;
                r_pend <= i_head.data.r1;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

`default_nettype wire

// File: design/dtok_checker.sv
// ----------------------------------------------------------------------------
// dtok_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dtok_checker
    import dtok_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [FIELD_W-1:0] o_token_offset,
    input wire logic [FIELD_W-1:0] o_token_length,
    input wire logic [1:0]         o_end_cause,
    input wire logic               o_final_result,
    input wire logic               pready
);

    // Output is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_token_offset)
            && $stable(o_token_length) && $stable(o_end_cause)
            && $stable(o_final_result))
        else $error("stalled result changed");

    // Only known end causes appear
    a_cause_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_end_cause == CAUSE_SEP || o_end_cause == CAUSE_NUL
            || o_end_cause == CAUSE_END))
        else $error("unknown end cause");

    // Only NUL and end of buffer close a buffer
    a_final_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_final_result == (o_end_cause != CAUSE_SEP)))
        else $error("final flag does not match end cause");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind delimiter_tokenizer dtok_checker u_dtok_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_token_offset (o_token_offset),
    .o_token_length (o_token_length),
    .o_end_cause    (o_end_cause),
    .o_final_result (o_final_result),
    .pready         (pready)
);

`default_nettype wire
